FILE: rtl/ucpd_pkg.sv
`timescale 1ns / 1ps

package ucpd_pkg;

  // decode_mode codes; the unused code behaves as windows-1252
  localparam logic [1:0] MODE_UTF16LE = 2'd0;
  localparam logic [1:0] MODE_UTF16BE = 2'd1;
  localparam logic [1:0] MODE_CP1252  = 2'd2;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;

  // surrogate ranges, 16-bit unit
  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;

  // windows-1252 remapped byte range
  localparam logic [7:0] CP1252_MAP_FIRST = 8'h80;
  localparam logic [7:0] CP1252_MAP_LAST  = 8'h9F;

  // one result as held in the output queue
  typedef struct packed {
    logic [CP_W-1:0] scalar;
    logic            last_result;
  } ucpd_result_t;

  // bytes 0x80..0x9F of windows-1252
  function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
    logic [15:0] cp;
    case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008D;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      5'd31: cp = 16'h0178;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

endpackage

FILE: rtl/ucpd_in_if.sv
`timescale 1ns / 1ps

// byte channel into the decoder
interface ucpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

FILE: rtl/ucpd_out_if.sv
`timescale 1ns / 1ps

// code point channel out of the decoder
interface ucpd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] scalar;
  logic        last_result;

  modport source (output valid, output scalar, output last_result, input ready);
  modport sink   (input valid, input scalar, input last_result, output ready);
endinterface

FILE: rtl/ucpd_cfg_if.sv
`timescale 1ns / 1ps

// mode register write channel
interface ucpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] decode_mode;

  modport source (output valid, output decode_mode, input ready);
  modport sink   (input valid, input decode_mode, output ready);
endinterface

FILE: rtl/utf16_cp1252_code_point_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Handshake
// in_ch     in   byte_value[7:0], last_byte      valid/ready
// out_ch    out  scalar[20:0], last_result       valid/ready
// cfg_ch    in   decode_mode[1:0]                valid/ready (ready tied high)
//
// One byte is accepted per cycle while in_ch.ready is high; it is held in the
// input register, decoded, and its results written to the result queue.
// Each byte gives 0, 1 or 2 code points; results leave at one per cycle
// while out_ch.ready is high, so two-result bytes fill the queue and stall in_ch.
// in_ch.ready drops when the result queue holds more than QUEUE_DEPTH-4 items.
// rst_n (synchronous) clears the mode, the stream state and the queue.
module utf16_cp1252_code_point_decoder #(
  parameter int unsigned QUEUE_DEPTH = 8   // power of two, at least 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ucpd_in_if.sink    in_ch,
  ucpd_out_if.source out_ch,
  ucpd_cfg_if.sink   cfg_ch
);
  import ucpd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(QUEUE_DEPTH - 4);

  // mode register
  logic [1:0] mode_r;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // stream state
  logic [7:0] held_byte_r,   held_byte_nxt;
  logic       have_held_r,   have_held_nxt;
  logic [9:0] pend_bits_r,   pend_bits_nxt;
  logic       have_pend_r,   have_pend_nxt;

  // result queue
  ucpd_result_t      queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic in_acc, out_pop;

  // decode signals
  logic              utf16;
  logic [15:0]       unit;
  logic              is_hi, is_lo;
  logic [CP_W-1:0]   joined_cp, lone_cp, byte_cp;
  logic              lone_emit;
  logic [1:0]        res_n;
  logic [CP_W-1:0]   cp0, cp1;
  ucpd_result_t      res0, res1;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (count_r <= READY_LIMIT);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_pop      = out_ch.valid & out_ch.ready;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF16LE;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.decode_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.byte_value;
      in_last_r <= in_ch.last_byte;
    end
  end

  // unit assembly and classification
  assign utf16 = (mode_r == MODE_UTF16LE) || (mode_r == MODE_UTF16BE);
  assign unit  = (mode_r == MODE_UTF16BE) ? {held_byte_r, in_byte_r}
                                          : {in_byte_r, held_byte_r};
  assign is_hi = (unit >= HI_SURR_FIRST) && (unit <= HI_SURR_LAST);
  assign is_lo = (unit >= LO_SURR_FIRST) && (unit <= LO_SURR_LAST);
  assign joined_cp = CP_SUPP_BASE + {1'b0, pend_bits_r, unit[9:0]};
  assign lone_cp   = (is_hi || is_lo) ? CP_REPLACEMENT : {5'd0, unit};
  // a high surrogate waits for its partner unless the document ends here
  assign lone_emit = !(is_hi && !in_last_r);

  // windows-1252 byte map
  always_comb begin
    if ((in_byte_r >= CP1252_MAP_FIRST) && (in_byte_r <= CP1252_MAP_LAST)) begin
      byte_cp = {5'd0, cp1252_high(in_byte_r[4:0])};
    end else begin
      byte_cp = {13'd0, in_byte_r};
    end
  end

  // per-byte decode: up to two results and the next stream state
  always_comb begin
    held_byte_nxt = held_byte_r;
    have_held_nxt = have_held_r;
    pend_bits_nxt = pend_bits_r;
    have_pend_nxt = have_pend_r;
    res_n = 2'd0;
    cp0   = CP_REPLACEMENT;
    cp1   = CP_REPLACEMENT;
    if (in_vld_r) begin
      if (utf16) begin
        if (!have_held_r) begin
          if (in_last_r) begin
            // odd trailing byte, after any pending high surrogate
            res_n = have_pend_r ? 2'd2 : 2'd1;
          end else begin
            held_byte_nxt = in_byte_r;
            have_held_nxt = 1'b1;
          end
        end else begin
          have_held_nxt = 1'b0;
          if (have_pend_r && is_lo) begin
            have_pend_nxt = 1'b0;
            cp0   = joined_cp;
            res_n = 2'd1;
          end else begin
            if (have_pend_r) begin
              // unpaired high surrogate
              have_pend_nxt = 1'b0;
              res_n = 2'd1;
            end
            if (is_hi && !in_last_r) begin
              pend_bits_nxt = unit[9:0];
              have_pend_nxt = 1'b1;
            end
            if (lone_emit) begin
              if (res_n == 2'd0) begin
                cp0   = lone_cp;
                res_n = 2'd1;
              end else begin
                cp1   = lone_cp;
                res_n = 2'd2;
              end
            end
          end
        end
      end else begin
        cp0   = byte_cp;
        res_n = 2'd1;
      end
      // end of document clears the stream
      if (in_last_r) begin
        held_byte_nxt = 8'd0;
        have_held_nxt = 1'b0;
        pend_bits_nxt = 10'd0;
        have_pend_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res0.scalar      = cp0;
    res0.last_result = in_last_r && (res_n == 2'd1);
    res1.scalar      = cp1;
    res1.last_result = in_last_r;
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r <= 8'd0;
      have_held_r <= 1'b0;
      pend_bits_r <= 10'd0;
      have_pend_r <= 1'b0;
    end else begin
      held_byte_r <= held_byte_nxt;
      have_held_r <= have_held_nxt;
      pend_bits_r <= pend_bits_nxt;
      have_pend_r <= have_pend_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (res_n == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // result queue pointers
  assign count_nxt = count_r + CNT_W'(res_n) - CNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(res_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_pop);
      count_r  <= count_nxt;
    end
  end

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.scalar      = queue_r[rd_ptr_r].scalar;
  assign out_ch.last_result = queue_r[rd_ptr_r].last_result;

endmodule

FILE: rtl/ucpd_checker.sv
`timescale 1ns / 1ps

module ucpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_scalar,
  input logic        out_last_result,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // queue is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // back-pressure on the input only comes from a filling result queue
  a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // every result is a Unicode code point
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scalar <= 21'h10FFFF))
    else $error("code point beyond U+10FFFF");

  // mode register never stalls a write
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("mode write stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_scalar) && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind utf16_cp1252_code_point_decoder ucpd_checker u_ucpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_scalar      (out_ch.scalar),
  .out_last_result (out_ch.last_result),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready)
);
